>>> rtl/dcds_pkg.sv
// dcds_pkg: shared constants, register codes and pipeline control struct
// for the disc cell director stamp block. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package dcds_pkg;

  localparam int unsigned COORD_BITS_DEF = 12;
  localparam int unsigned FRAC_BITS_DEF  = 14;
  localparam int unsigned DIR_W          = 16;
  localparam int unsigned CFG_IDX_W      = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CENTRE_X   = 2'd0,
    REG_CENTRE_Y   = 2'd1,
    REG_RADIUS     = 2'd2,
    REG_ANCHORING  = 2'd3
  } cfg_reg_e;

  // control bits that ride along with each item
  typedef struct packed {
    logic accepted;
    logic write_cell;
    logic zero_dir;
    logic neg_x;
    logic neg_y;
  } ctrl_t;

endpackage

`default_nettype wire

>>> rtl/dcds_if.sv
// dcds_in_if, dcds_out_if, dcds_cfg_if: valid/ready channels of the block.
// Depends on dcds_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface dcds_in_if #(
  parameter int unsigned CW = dcds_pkg::COORD_BITS_DEF
);
  logic          valid;
  logic          ready;
  logic [CW-1:0] cell_x;
  logic [CW-1:0] cell_y;
  logic          operation;
  logic          cell_is_particle;

  modport source (output valid, cell_x, cell_y, operation, cell_is_particle, input ready);
  modport sink (input valid, cell_x, cell_y, operation, cell_is_particle, output ready);
endinterface

interface dcds_out_if;
  logic                                valid;
  logic                                ready;
  logic                                accepted;
  logic                                write_cell;
  logic signed [dcds_pkg::DIR_W-1:0]   director_x;
  logic signed [dcds_pkg::DIR_W-1:0]   director_y;

  modport source (output valid, accepted, write_cell, director_x, director_y, input ready);
  modport sink (input valid, accepted, write_cell, director_x, director_y, output ready);
endinterface

interface dcds_cfg_if #(
  parameter int unsigned CW = dcds_pkg::COORD_BITS_DEF
);
  logic                              valid;
  logic                              ready;
  logic [dcds_pkg::CFG_IDX_W-1:0]    index;
  logic [CW-1:0]                     data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> rtl/dcds_geom.sv
// dcds_geom: three register stages computing offsets, squares, the inside
// test, the result flags and the per-lane bounds for the root search. Uses dcds_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dcds_geom #(
  parameter int unsigned COORD_BITS = dcds_pkg::COORD_BITS_DEF,
  parameter int unsigned FRAC_BITS  = dcds_pkg::FRAC_BITS_DEF,
  parameter int unsigned DW         = 2 * COORD_BITS + 1,
  parameter int unsigned PW         = 2 * COORD_BITS + 2 * FRAC_BITS + 7
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          valid_i,
  output logic                         ready_o,
  input  wire [COORD_BITS-1:0]         cell_x_i,
  input  wire [COORD_BITS-1:0]         cell_y_i,
  input  wire                          operation_i,
  input  wire                          busy_i,
  input  wire [COORD_BITS-1:0]         centre_x_i,
  input  wire [COORD_BITS-1:0]         centre_y_i,
  input  wire [COORD_BITS-1:0]         radius_i,
  input  wire                          radial_i,
  output logic                         valid_o,
  input  wire                          ready_i,
  output dcds_pkg::ctrl_t              ctrl_o,
  output logic [DW-1:0]                d2_o,
  output logic signed [PW-1:0]         rhs_x_o,
  output logic signed [PW-1:0]         rhs_y_o
);
  import dcds_pkg::*;

  localparam int unsigned CW  = COORD_BITS;
  localparam int unsigned SQW = 2 * COORD_BITS;

  logic v1_q, v2_q, v3_q;
  logic rdy1, rdy2, rdy3;

  // stage 1: offsets
  logic signed [CW:0] dx, dy;
  logic [CW-1:0] adx_q, ady_q;
  logic sx_q, sy_q, dxnz_q, op1_q, busy1_q;

  // stage 2: squares
  logic [SQW-1:0] ax2_q, ay2_q, rlim_q;
  logic sx2_q, sy2_q, dxnz2_q, op2_q, busy2_q, rnz_q;

  // stage 3: inside test and lane setup
  logic [DW-1:0]   d2;
  logic            in_disc, acc, wr;
  logic [SQW-1:0]  magx, magy;
  logic            negx, negy;

  assign rdy3    = !v3_q || ready_i;
  assign rdy2    = !v2_q || rdy3;
  assign rdy1    = !v1_q || rdy2;
  assign ready_o = rdy1;
  assign valid_o = v3_q;

  assign dx = $signed({1'b0, cell_x_i}) - $signed({1'b0, centre_x_i});
  assign dy = $signed({1'b0, cell_y_i}) - $signed({1'b0, centre_y_i});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      adx_q   <= dx[CW] ? CW'(-dx) : CW'(dx);
      ady_q   <= dy[CW] ? CW'(-dy) : CW'(dy);
      sx_q    <= dx[CW];
      sy_q    <= dy[CW];
      dxnz_q  <= (dx != '0);
      op1_q   <= operation_i;
      busy1_q <= busy_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy2) begin
      ax2_q   <= adx_q * adx_q;
      ay2_q   <= ady_q * ady_q;
      rlim_q  <= SQW'(radius_i) * SQW'(radius_i) - SQW'(radius_i);
      rnz_q   <= (radius_i != '0);
      sx2_q   <= sx_q;
      sy2_q   <= sy_q;
      dxnz2_q <= dxnz_q;
      op2_q   <= op1_q;
      busy2_q <= busy1_q;
    end
  end

  always_comb begin
    d2      = DW'(ax2_q) + DW'(ay2_q);
    in_disc = rnz_q && (d2 <= DW'(rlim_q));
    acc     = !(in_disc && busy2_q);
    wr      = in_disc && !busy2_q && op2_q;
    // perpendicular: (dx, dy); parallel: (dy, -dx)
    if (radial_i) begin
      magx = ax2_q;
      negx = sx2_q;
      magy = ay2_q;
      negy = sy2_q;
    end else begin
      magx = ay2_q;
      negx = sy2_q;
      magy = ax2_q;
      negy = !sx2_q && dxnz2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy3) begin
      d2_o              <= d2;
      ctrl_o.accepted   <= acc;
      ctrl_o.write_cell <= wr;
      ctrl_o.zero_dir   <= !wr || (d2 == '0);
      ctrl_o.neg_x      <= negx;
      ctrl_o.neg_y      <= negy;
      rhs_x_o           <= $signed(PW'(magx) << (2 * FRAC_BITS + 2));
      rhs_y_o           <= $signed(PW'(magy) << (2 * FRAC_BITS + 2));
    end
  end

endmodule

`default_nettype wire

>>> rtl/dcds_root_step.sv
// dcds_root_step: one bit of the rounded ratio search for both director
// lanes, one register stage. Uses dcds_pkg for the control struct.
`timescale 1ns / 1ps
`default_nettype none

module dcds_root_step #(
  parameter int unsigned BIT = 0,
  parameter int unsigned DW  = 25,
  parameter int unsigned PW  = 59,
  parameter int unsigned NW  = 15
) (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    valid_i,
  output logic                   ready_o,
  output logic                   valid_o,
  input  wire                    ready_i,
  input  dcds_pkg::ctrl_t        ctrl_i,
  input  wire [DW-1:0]           d2_i,
  input  wire signed [PW-1:0]    p_i   [2],
  input  wire signed [PW-1:0]    q_i   [2],
  input  wire signed [PW-1:0]    rhs_i [2],
  input  wire [NW-1:0]           n_i   [2],
  output dcds_pkg::ctrl_t        ctrl_o,
  output logic [DW-1:0]          d2_o,
  output logic signed [PW-1:0]   p_o   [2],
  output logic signed [PW-1:0]   q_o   [2],
  output logic signed [PW-1:0]   rhs_o [2],
  output logic [NW-1:0]          n_o   [2]
);
  import dcds_pkg::*;

  // p = t*t*d2 and q = t*d2 with t = 2n-1; trying bit BIT adds 2^(BIT+1) to t
  logic signed [PW-1:0] d2w;
  logic signed [PW-1:0] cand [2];
  logic signed [PW-1:0] qnew [2];
  logic                 take [2];
  logic                 v_q;

  assign ready_o = !v_q || ready_i;
  assign valid_o = v_q;
  assign d2w     = $signed(PW'(d2_i));

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      cand[l] = p_i[l] + (q_i[l] <<< (BIT + 2)) + (d2w <<< (2 * BIT + 2));
      qnew[l] = q_i[l] + (d2w <<< (BIT + 1));
      take[l] = (cand[l] <= rhs_i[l]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (ready_o) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o) begin
      ctrl_o <= ctrl_i;
      d2_o   <= d2_i;
      for (int l = 0; l < 2; l++) begin
        rhs_o[l] <= rhs_i[l];
        p_o[l]   <= take[l] ? cand[l] : p_i[l];
        q_o[l]   <= take[l] ? qnew[l] : q_i[l];
        n_o[l]   <= n_i[l] | (take[l] ? (NW'(1) << BIT) : '0);
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/disc_cell_director_stamp.sv
// disc_cell_director_stamp: top level with configuration registers, the
// geometry front, the bit-serial root chain and the output register.
// Depends on dcds_pkg, dcds_if, dcds_geom and dcds_root_step.
//
//   channel  dir  handshake            payload
//   in_i     in   valid / ready        cell_x, cell_y, operation, cell_is_particle
//   out_o    out  valid / ready        accepted, write_cell, director_x, director_y
//   cfg_i    in   valid / ready (=1)   index, data
//
// one item per cycle sustained while out_o is ready; FRAC_BITS + 5 register
// stages (19 at default): three geometry stages, one stage per result bit
// of the director search, one output stage. each stage holds its item until
// the next one is free, so bubbles close up under a stall. reset clears
// valid bits and restores the register defaults; no memory and no clearing
// pass.
`timescale 1ns / 1ps
`default_nettype none

module disc_cell_director_stamp #(
  parameter int unsigned COORD_BITS = dcds_pkg::COORD_BITS_DEF,
  parameter int unsigned FRAC_BITS  = dcds_pkg::FRAC_BITS_DEF
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  dcds_in_if.sink     in_i,
  dcds_out_if.source  out_o,
  dcds_cfg_if.sink    cfg_i
);
  import dcds_pkg::*;

  localparam int unsigned DW = 2 * COORD_BITS + 1;
  localparam int unsigned PW = 2 * COORD_BITS + 2 * FRAC_BITS + 7;
  localparam int unsigned NW = FRAC_BITS + 1;
  localparam int unsigned XW = (NW + 1 > DIR_W) ? NW + 1 : DIR_W;
  localparam int unsigned NS = FRAC_BITS + 2;

  logic [COORD_BITS-1:0] centre_x_q, centre_y_q, radius_q;
  logic                  radial_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      centre_x_q <= '0;
      centre_y_q <= '0;
      radius_q   <= COORD_BITS'(1);
      radial_q   <= 1'b0;
    end else if (cfg_i.valid) begin
      unique case (cfg_reg_e'(cfg_i.index))
        REG_CENTRE_X:  centre_x_q <= cfg_i.data;
        REG_CENTRE_Y:  centre_y_q <= cfg_i.data;
        REG_RADIUS:    radius_q   <= cfg_i.data;
        REG_ANCHORING: radial_q   <= cfg_i.data[0];
        default:       ;
      endcase
    end
  end

  // search chain nodes; node 0 comes from the geometry front
  logic                 v_c   [NS];
  logic                 r_c   [NS];
  ctrl_t                ctrl_c[NS];
  logic [DW-1:0]        d2_c  [NS];
  logic signed [PW-1:0] p_c   [NS][2];
  logic signed [PW-1:0] q_c   [NS][2];
  logic signed [PW-1:0] rhs_c [NS][2];
  logic [NW-1:0]        n_c   [NS][2];

  dcds_geom #(
    .COORD_BITS(COORD_BITS),
    .FRAC_BITS (FRAC_BITS),
    .DW        (DW),
    .PW        (PW)
  ) u_geom (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (in_i.valid),
    .ready_o    (in_i.ready),
    .cell_x_i   (in_i.cell_x),
    .cell_y_i   (in_i.cell_y),
    .operation_i(in_i.operation),
    .busy_i     (in_i.cell_is_particle),
    .centre_x_i (centre_x_q),
    .centre_y_i (centre_y_q),
    .radius_i   (radius_q),
    .radial_i   (radial_q),
    .valid_o    (v_c[0]),
    .ready_i    (r_c[0]),
    .ctrl_o     (ctrl_c[0]),
    .d2_o       (d2_c[0]),
    .rhs_x_o    (rhs_c[0][0]),
    .rhs_y_o    (rhs_c[0][1])
  );

  // start of search: n = 0, t = -1, so p = d2 and q = -d2
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      p_c[0][l] = $signed(PW'(d2_c[0]));
      q_c[0][l] = -$signed(PW'(d2_c[0]));
      n_c[0][l] = '0;
    end
  end

  for (genvar k = 0; k < NS - 1; k++) begin : g_step
    dcds_root_step #(
      .BIT(FRAC_BITS - k),
      .DW (DW),
      .PW (PW),
      .NW (NW)
    ) u_step (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .valid_i(v_c[k]),
      .ready_o(r_c[k]),
      .valid_o(v_c[k+1]),
      .ready_i(r_c[k+1]),
      .ctrl_i (ctrl_c[k]),
      .d2_i   (d2_c[k]),
      .p_i    (p_c[k]),
      .q_i    (q_c[k]),
      .rhs_i  (rhs_c[k]),
      .n_i    (n_c[k]),
      .ctrl_o (ctrl_c[k+1]),
      .d2_o   (d2_c[k+1]),
      .p_o    (p_c[k+1]),
      .q_o    (q_c[k+1]),
      .rhs_o  (rhs_c[k+1]),
      .n_o    (n_c[k+1])
    );
  end

  // output register
  logic                    out_v_q;
  logic                    acc_q, wr_q;
  logic signed [DIR_W-1:0] dir_x_q, dir_y_q;
  logic signed [XW-1:0]    ext_x, ext_y;

  assign r_c[NS-1] = !out_v_q || out_o.ready;

  always_comb begin
    ext_x = $signed(XW'(n_c[NS-1][0]));
    ext_y = $signed(XW'(n_c[NS-1][1]));
    if (ctrl_c[NS-1].neg_x) ext_x = -ext_x;
    if (ctrl_c[NS-1].neg_y) ext_y = -ext_y;
    if (ctrl_c[NS-1].zero_dir) begin
      ext_x = '0;
      ext_y = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (r_c[NS-1]) begin
      out_v_q <= v_c[NS-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (r_c[NS-1]) begin
      acc_q   <= ctrl_c[NS-1].accepted;
      wr_q    <= ctrl_c[NS-1].write_cell;
      dir_x_q <= ext_x[DIR_W-1:0];
      dir_y_q <= ext_y[DIR_W-1:0];
    end
  end

  assign out_o.valid      = out_v_q;
  assign out_o.accepted   = acc_q;
  assign out_o.write_cell = wr_q;
  assign out_o.director_x = dir_x_q;
  assign out_o.director_y = dir_y_q;

  // a written cell is never a rejected one
  a_write_implies_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q |-> (!wr_q || acc_q))
    else $error("write_cell without accepted");

  // no director unless the cell is written
  a_no_write_zero_dir: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && !wr_q) |-> (dir_x_q == '0 && dir_y_q == '0))
    else $error("director nonzero without write");

  // a held result keeps the last search stage frozen
  a_chain_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && !out_o.ready && v_c[NS-1]) |=> (v_c[NS-1] && $stable(n_c[NS-1][0])))
    else $error("search stage advanced under stall");

endmodule

`default_nettype wire
